[rtl/core/multiplexed_timer_array_unit_defines.svh]
// Assertion macros for the multiplexed timer array unit.
// Included by files that carry concurrent assertions; depends on nothing else.
`ifndef MULTIPLEXED_TIMER_ARRAY_UNIT_DEFINES_SVH
`define MULTIPLEXED_TIMER_ARRAY_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define MTA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define MTA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mta_pkg.sv]
// Shared types and constants of the multiplexed timer array unit.
// Used by the channel interfaces, the divider and the top level; no dependencies.
package mta_pkg;

    localparam int CMD_W      = 3;
    localparam int ID_W       = 4;
    localparam int FIELD_W    = 16;
    localparam int MAX_FIRES  = 64;
    localparam int FIRE_CNT_W = 7;

    localparam logic [FIELD_W-1:0] DEFAULT_LATE_WINDOW = 16'd1000;

    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ATTACH = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DETACH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CHANGE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SYNC   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FIRE   = 3'd5;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[rtl/core/mta_req_if.sv]
// Command channel of the multiplexed timer array unit: valid, ready and one command.
// Depends on mta_pkg for the field widths.
interface mta_req_if;
    import mta_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [ID_W-1:0]    timer_id;
    logic [ID_W-1:0]    reference_id;
    logic [FIELD_W-1:0] delay;
    logic               periodic;
    logic [FIELD_W-1:0] now_count;

    modport source (output valid, cmd, timer_id, reference_id, delay, periodic, now_count,
                    input ready);
    modport sink   (input valid, cmd, timer_id, reference_id, delay, periodic, now_count,
                    output ready);
endinterface

[rtl/core/mta_res_if.sv]
// Result channel of the multiplexed timer array unit: valid, ready and one result.
// Depends on mta_pkg for the field widths.
interface mta_res_if;
    import mta_pkg::*;

    logic               valid;
    logic               ready;
    logic               fired;
    logic [ID_W-1:0]    fired_id;
    logic [FIELD_W-1:0] compare_value;
    logic               last;

    modport source (output valid, fired, fired_id, compare_value, last, input ready);
    modport sink   (input valid, fired, fired_id, compare_value, last, output ready);
endinterface

[rtl/core/mta_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mta_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

[rtl/core/mta_div.sv]
// Restoring remainder unit, one quotient bit per cycle, for attach in sync.
// Depends on mta_pkg for the status struct.
module mta_div #(
    parameter int W = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [W-1:0]         dividend,
    input  logic [W-1:0]         divisor,
    output mta_pkg::div_stat_t   stat,
    output logic [W-1:0]         rem
);
    import mta_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dvd_reg;
    logic [W-1:0]     dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [W:0]       trial;
    logic [W:0]       diff;

    assign trial = {rem_reg, dvd_reg[W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dvd_reg  <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= '0;
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
                cnt_reg  <= CNT_W'(W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // The partial remainder stays below the divisor, so W bits suffice.
                rem_reg <= diff[W] ? trial[W-1:0] : diff[W-1:0];
                dvd_reg <= {dvd_reg[W-2:0], 1'b0};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;
endmodule

[rtl/core/multiplexed_timer_array_unit.sv]
// Multiplexed timer array unit: timer slots held in one RAM, scanned by a sequencer.
// Depends on mta_pkg, mta_req_if, mta_res_if, mta_ram, mta_div and the defines header.
//
// Usage: commands arrive on the req channel, one transfer each; results leave on the
// res channel. Every command gives one result, a tick one per timer fired (at most 64),
// and the final result of a command carries last. The user must write late_window
// by late_window_we/late_window_wdata only while the unit is idle; nothing enforces it.
// Scanning: slot data lives in a RAM with one read port, so every search of the slots
// walks it one entry a cycle. A plain command makes one search for the next compare
// value; attach in sync first waits for its remainder from the divider. A tick first
// searches for the most overdue slot, then per timer fired for the next compare value
// and once more for a due timer; if none fires, a search for the compare value follows.
// A new command is taken only once the previous one has finished; its last result may
// still wait in the output register. Results move on when res.ready is high; while it
// is low and a result waits, the sequencer holds before the next, the RAM state untouched.
// Reset stops every timer and sets late_window to 1000; slots that were never written
// read as zero, so no clearing pass is needed.
module multiplexed_timer_array_unit #(
    parameter int NUM_TIMERS   = 16,
    parameter int COUNTER_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     late_window_we,
    input  logic [mta_pkg::FIELD_W-1:0] late_window_wdata,
    mta_req_if.sink                  req,
    mta_res_if.source                res
);
    import mta_pkg::*;

    `include "multiplexed_timer_array_unit_defines.svh"

    localparam int CW = COUNTER_BITS;
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SW = $clog2(NUM_TIMERS + 1);
    localparam int EW = 2 * CW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_DEC, S_DIV, S_WRITE, S_FSCAN, S_CSCAN, S_EMIT, S_FUPD
    } state_t;

    state_t state_reg;

    logic [FIELD_W-1:0]    win_reg;
    logic [CMD_W-1:0]      cmd_reg;
    logic [ID_W-1:0]       id_reg;
    logic [ID_W-1:0]       ref_reg;
    logic [CW-1:0]         dly_reg;
    logic                  per_reg;
    logic [CW-1:0]         now_reg;
    logic                  ok_reg;
    logic                  ref_ok_reg;
    logic [NUM_TIMERS-1:0] running_reg;
    logic [NUM_TIMERS-1:0] wbit_reg;
    logic [SW-1:0]         scan_cnt_reg;
    logic [IW-1:0]         rd_idx_reg;
    logic                  rd_v_reg;
    logic                  fb_v_reg;
    logic [IW-1:0]         fb_idx_reg;
    logic [CW-1:0]         fb_late_reg;
    logic [CW-1:0]         fb_t_reg;
    logic [CW-1:0]         fb_d_reg;
    logic                  fb_p_reg;
    logic                  cb_v_reg;
    logic [CW-1:0]         cb_t_reg;
    logic [CW-1:0]         cb_key_reg;
    logic                  pend_v_reg;
    logic                  pend_fired_reg;
    logic [ID_W-1:0]       pend_id_reg;
    logic [CW-1:0]         pend_cmp_reg;
    logic                  last_reg;
    logic [FIRE_CNT_W-1:0] fire_cnt_reg;
    logic                  we_reg;
    logic [EW-1:0]         wdat_reg;
    logic                  set_run_reg;
    logic                  clr_run_reg;
    logic                  div_start_reg;
    logic [CW-1:0]         div_dvd_reg;
    logic                  res_v_reg;
    logic                  res_fired_reg;
    logic [ID_W-1:0]       res_id_reg;
    logic [FIELD_W-1:0]    res_cmp_reg;
    logic                  res_last_reg;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] ram_q;
    logic [EW-1:0] q_eff;
    logic [CW-1:0] q_t;
    logic [CW-1:0] q_d;
    logic          q_p;
    logic [IW-1:0] id_idx;
    logic          run_id;
    logic [CW-1:0] late_w;
    logic [CW-1:0] key_w;
    logic          fire_due;
    logic          scan_end;
    logic          out_free;
    logic [CW-1:0] fupd_tgt;

    div_stat_t     div_stat;
    logic [CW-1:0] div_rem;
    logic [CW-1:0] sync_tgt;

    logic          dec_we;
    logic          dec_set;
    logic          dec_clr;
    logic          dec_fired;
    logic          dec_div;
    logic [EW-1:0] dec_wdat;
    logic [CW-1:0] dec_rem;
    logic [CW-1:0] dec_elapsed;
    logic [CW-1:0] dec_start;
    logic [CW-1:0] dec_diff;
    logic [CW-1:0] now_plus_dly;
    logic [CW-1:0] now_plus_qd;
    logic [CW-1:0] chg_tgt;

    mta_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_TIMERS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    mta_div #(
        .W (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dvd_reg),
        .divisor  (dly_reg),
        .stat     (div_stat),
        .rem      (div_rem)
    );

    assign id_idx   = IW'(id_reg);
    assign run_id   = running_reg[id_idx];
    assign fupd_tgt = fb_t_reg + fb_d_reg;
    assign sync_tgt = now_reg + (dly_reg - div_rem);

    // Write port: command write-back or re-arming of a periodic timer after a tick fire.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = id_idx;
        ram_wdata = wdat_reg;
        if (state_reg == S_WRITE)
        begin
            ram_we = we_reg;
        end
        else if (state_reg == S_FUPD)
        begin
            ram_we    = fb_p_reg;
            ram_waddr = fb_idx_reg;
            ram_wdata = {fb_p_reg, fb_d_reg, fupd_tgt};
        end
    end

    always_comb
    begin
        ram_raddr = scan_cnt_reg[IW-1:0];
        if (state_reg == S_RD)
        begin
            ram_raddr = (cmd_reg == CMD_SYNC) ? IW'(ref_reg) : id_idx;
        end
    end

    // A slot that was never written reads as its reset value of zero.
    assign q_eff    = wbit_reg[rd_idx_reg] ? ram_q : '0;
    assign q_t      = q_eff[CW-1:0];
    assign q_d      = q_eff[2*CW-1:CW];
    assign q_p      = q_eff[2*CW];
    assign late_w   = now_reg - q_t;
    assign key_w    = q_t - now_reg;
    assign fire_due = running_reg[rd_idx_reg] && (32'(late_w) < 32'(win_reg));
    assign scan_end = (scan_cnt_reg == SW'(NUM_TIMERS)) && !rd_v_reg;
    assign out_free = !res_v_reg || res.ready;

    assign dec_rem      = q_t - now_reg;
    assign dec_elapsed  = q_d - dec_rem;
    // Attach in sync on its own slot uses the new delay that it is about to store.
    assign dec_start    = q_t - ((ref_reg == id_reg) ? dly_reg : q_d);
    assign dec_diff     = now_reg - dec_start;
    assign now_plus_dly = now_reg + dly_reg;
    assign now_plus_qd  = now_reg + q_d;

    // An overdue timer, or one that has already waited longer than the new delay,
    // fires at once and restarts from now.
    always_comb
    begin
        if ((dec_rem > q_d) || (dec_elapsed > dly_reg))
        begin
            chg_tgt = now_plus_dly;
        end
        else
        begin
            chg_tgt = q_t + dly_reg - q_d;
        end
    end

    always_comb
    begin
        dec_we    = 1'b0;
        dec_set   = 1'b0;
        dec_clr   = 1'b0;
        dec_fired = 1'b0;
        dec_div   = 1'b0;
        dec_wdat  = {q_p, q_d, q_t};
        case (cmd_reg)
            CMD_ATTACH:
            begin
                if (ok_reg && !run_id)
                begin
                    dec_we   = 1'b1;
                    dec_set  = 1'b1;
                    dec_wdat = {per_reg, dly_reg, now_plus_dly};
                end
            end
            CMD_DETACH:
            begin
                dec_clr = ok_reg;
            end
            CMD_CHANGE:
            begin
                if (ok_reg && (dly_reg != '0))
                begin
                    dec_we = 1'b1;
                    if (!run_id)
                    begin
                        dec_wdat = {q_p, dly_reg, q_t};
                    end
                    else
                    begin
                        dec_fired = (dec_rem > q_d) || (dec_elapsed > dly_reg);
                        dec_wdat  = {q_p, dly_reg, chg_tgt};
                    end
                end
            end
            CMD_SYNC:
            begin
                if (ok_reg && ref_ok_reg && !run_id)
                begin
                    if (dly_reg == '0)
                    begin
                        dec_we   = 1'b1;
                        dec_set  = 1'b1;
                        dec_wdat = {per_reg, dly_reg, now_reg};
                    end
                    else
                    begin
                        dec_div = 1'b1;
                    end
                end
            end
            CMD_FIRE:
            begin
                if (ok_reg)
                begin
                    dec_fired = 1'b1;
                    if (q_p)
                    begin
                        dec_we   = 1'b1;
                        dec_set  = 1'b1;
                        dec_wdat = {q_p, q_d, now_plus_qd};
                    end
                    else
                    begin
                        dec_clr = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            win_reg        <= DEFAULT_LATE_WINDOW;
            cmd_reg        <= CMD_TICK;
            id_reg         <= '0;
            ref_reg        <= '0;
            dly_reg        <= '0;
            per_reg        <= 1'b0;
            now_reg        <= '0;
            ok_reg         <= 1'b0;
            ref_ok_reg     <= 1'b0;
            running_reg    <= '0;
            wbit_reg       <= '0;
            scan_cnt_reg   <= '0;
            rd_idx_reg     <= '0;
            rd_v_reg       <= 1'b0;
            fb_v_reg       <= 1'b0;
            fb_idx_reg     <= '0;
            fb_late_reg    <= '0;
            fb_t_reg       <= '0;
            fb_d_reg       <= '0;
            fb_p_reg       <= 1'b0;
            cb_v_reg       <= 1'b0;
            cb_t_reg       <= '0;
            cb_key_reg     <= '0;
            pend_v_reg     <= 1'b0;
            pend_fired_reg <= 1'b0;
            pend_id_reg    <= '0;
            pend_cmp_reg   <= '0;
            last_reg       <= 1'b0;
            fire_cnt_reg   <= '0;
            we_reg         <= 1'b0;
            wdat_reg       <= '0;
            set_run_reg    <= 1'b0;
            clr_run_reg    <= 1'b0;
            div_start_reg  <= 1'b0;
            div_dvd_reg    <= '0;
            res_v_reg      <= 1'b0;
            res_fired_reg  <= 1'b0;
            res_id_reg     <= '0;
            res_cmp_reg    <= '0;
            res_last_reg   <= 1'b0;
        end
        else
        begin
            if (late_window_we)
            begin
                win_reg <= late_window_wdata;
            end
            if (res.ready && !((state_reg == S_EMIT) && out_free))
            begin
                res_v_reg <= 1'b0;
            end
            div_start_reg <= 1'b0;
            rd_idx_reg    <= ram_raddr;
            rd_v_reg      <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        cmd_reg      <= req.cmd;
                        id_reg       <= req.timer_id;
                        ref_reg      <= req.reference_id;
                        dly_reg      <= CW'(req.delay);
                        per_reg      <= req.periodic;
                        now_reg      <= CW'(req.now_count);
                        ok_reg       <= int'(req.timer_id) < NUM_TIMERS;
                        ref_ok_reg   <= int'(req.reference_id) < NUM_TIMERS;
                        fire_cnt_reg <= '0;
                        pend_v_reg   <= 1'b0;
                        scan_cnt_reg <= '0;
                        fb_v_reg     <= 1'b0;
                        state_reg    <= (req.cmd == CMD_TICK) ? S_FSCAN : S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    we_reg         <= dec_we;
                    wdat_reg       <= dec_wdat;
                    set_run_reg    <= dec_set;
                    clr_run_reg    <= dec_clr;
                    pend_fired_reg <= dec_fired;
                    pend_id_reg    <= dec_fired ? id_reg : '0;
                    div_dvd_reg    <= dec_diff;
                    div_start_reg  <= dec_div;
                    state_reg      <= dec_div ? S_DIV : S_WRITE;
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        we_reg      <= 1'b1;
                        set_run_reg <= 1'b1;
                        wdat_reg    <= {per_reg, dly_reg, sync_tgt};
                        state_reg   <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (set_run_reg)
                    begin
                        running_reg[id_idx] <= 1'b1;
                    end
                    else if (clr_run_reg)
                    begin
                        running_reg[id_idx] <= 1'b0;
                    end
                    if (we_reg)
                    begin
                        wbit_reg[id_idx] <= 1'b1;
                    end
                    scan_cnt_reg <= '0;
                    cb_v_reg     <= 1'b0;
                    state_reg    <= S_CSCAN;
                end
                S_FSCAN:
                begin
                    if (scan_cnt_reg != SW'(NUM_TIMERS))
                    begin
                        scan_cnt_reg <= scan_cnt_reg + SW'(1);
                        rd_v_reg     <= 1'b1;
                    end
                    // Strictly larger lateness wins, so ties stay with the lower slot.
                    if (rd_v_reg && fire_due && (!fb_v_reg || (late_w > fb_late_reg)))
                    begin
                        fb_v_reg    <= 1'b1;
                        fb_idx_reg  <= rd_idx_reg;
                        fb_late_reg <= late_w;
                        fb_t_reg    <= q_t;
                        fb_d_reg    <= q_d;
                        fb_p_reg    <= q_p;
                    end
                    if (scan_end)
                    begin
                        if (pend_v_reg)
                        begin
                            last_reg  <= !fb_v_reg;
                            state_reg <= S_EMIT;
                        end
                        else if (fb_v_reg)
                        begin
                            state_reg <= S_FUPD;
                        end
                        else
                        begin
                            pend_fired_reg <= 1'b0;
                            pend_id_reg    <= '0;
                            scan_cnt_reg   <= '0;
                            cb_v_reg       <= 1'b0;
                            state_reg      <= S_CSCAN;
                        end
                    end
                end
                S_FUPD:
                begin
                    if (!fb_p_reg)
                    begin
                        running_reg[fb_idx_reg] <= 1'b0;
                    end
                    else
                    begin
                        wbit_reg[fb_idx_reg] <= 1'b1;
                    end
                    fire_cnt_reg   <= fire_cnt_reg + FIRE_CNT_W'(1);
                    pend_fired_reg <= 1'b1;
                    pend_id_reg    <= ID_W'(fb_idx_reg);
                    scan_cnt_reg   <= '0;
                    cb_v_reg       <= 1'b0;
                    state_reg      <= S_CSCAN;
                end
                S_CSCAN:
                begin
                    if (scan_cnt_reg != SW'(NUM_TIMERS))
                    begin
                        scan_cnt_reg <= scan_cnt_reg + SW'(1);
                        rd_v_reg     <= 1'b1;
                    end
                    if (rd_v_reg && running_reg[rd_idx_reg]
                        && (!cb_v_reg || (key_w < cb_key_reg)))
                    begin
                        cb_v_reg   <= 1'b1;
                        cb_t_reg   <= q_t;
                        cb_key_reg <= key_w;
                    end
                    if (scan_end)
                    begin
                        pend_cmp_reg <= cb_v_reg ? cb_t_reg : (now_reg - CW'(1));
                        if ((cmd_reg == CMD_TICK) && (fire_cnt_reg != '0)
                            && (fire_cnt_reg != FIRE_CNT_W'(MAX_FIRES)))
                        begin
                            // Whether this fire is the final result is known only
                            // after the next search for a due timer.
                            pend_v_reg   <= 1'b1;
                            scan_cnt_reg <= '0;
                            fb_v_reg     <= 1'b0;
                            state_reg    <= S_FSCAN;
                        end
                        else
                        begin
                            last_reg  <= 1'b1;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        res_v_reg     <= 1'b1;
                        res_fired_reg <= pend_fired_reg;
                        res_id_reg    <= pend_id_reg;
                        res_cmp_reg   <= FIELD_W'(pend_cmp_reg);
                        res_last_reg  <= last_reg;
                        if (last_reg)
                        begin
                            pend_v_reg <= 1'b0;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_FUPD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign res.valid         = res_v_reg;
    assign res.fired         = res_fired_reg;
    assign res.fired_id      = res_id_reg;
    assign res.compare_value = res_cmp_reg;
    assign res.last          = res_last_reg;

    `MTA_ASSERT_IMP(a_fire_cap, clk, rst_n, state_reg == S_FUPD, fire_cnt_reg < FIRE_CNT_W'(MAX_FIRES), "tick fired more timers than allowed")
    `MTA_ASSERT_IMP(a_quiet_id, clk, rst_n, res.valid && !res.fired, res.fired_id == '0, "result without a fire carries a slot number")
    `MTA_ASSERT_NXT(a_busy_after_take, clk, rst_n, req.valid && req.ready, state_reg != S_IDLE, "command transfer did not start the sequencer")
endmodule

[test/multiplexed_timer_array_unit_checker.sv]
// Checker for the multiplexed timer array unit: watches the command and result channels,
// predicts the fire results of every accepted command and compares them in order.
// Depends on mta_pkg, mta_req_if and mta_res_if.
module multiplexed_timer_array_unit_checker
    import mta_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               late_window_we,
    input  logic [FIELD_W-1:0] late_window_wdata,
    mta_req_if                 req,
    mta_res_if                 res,
    output int                 fail_count,
    output int                 pending_count,
    output int                 result_count,
    output int                 fire_count
);
    localparam int SLOTS = 16;

    typedef struct packed {
        logic               fired;
        logic [ID_W-1:0]    fired_id;
        logic [FIELD_W-1:0] compare_value;
        logic               last;
    } fire_rec_t;

    fire_rec_t          due_results[$];
    logic [FIELD_W-1:0] window;
    logic [FIELD_W-1:0] slot_tgt [SLOTS];
    logic [FIELD_W-1:0] slot_dly [SLOTS];
    logic               slot_per [SLOTS];
    logic               slot_run [SLOTS];

    // Earliest running target as seen from now; with no timer running, now minus one.
    function automatic logic [FIELD_W-1:0] next_compare(logic [FIELD_W-1:0] now);
        int                 best;
        logic [FIELD_W-1:0] best_key;
        logic [FIELD_W-1:0] key;
        best = -1;
        best_key = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            key = slot_tgt[i] - now;
            if (slot_run[i] && (best < 0 || key < best_key))
            begin
                best = i;
                best_key = key;
            end
        end
        if (best < 0)
            return now - 16'd1;
        return slot_tgt[best];
    endfunction

    function automatic void push_result(logic f, logic [ID_W-1:0] id, logic [FIELD_W-1:0] now);
        fire_rec_t r;
        r.fired = f;
        r.fired_id = f ? id : '0;
        r.compare_value = next_compare(now);
        r.last = 1'b0;
        due_results.push_back(r);
    endfunction

    function automatic void predict_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                            logic [ID_W-1:0] rid, logic [FIELD_W-1:0] dl,
                                            logic per, logic [FIELD_W-1:0] now);
        int                 n;
        int                 best;
        logic [FIELD_W-1:0] best_late;
        logic [FIELD_W-1:0] late;
        logic [FIELD_W-1:0] old;
        logic [FIELD_W-1:0] rem;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] diff;
        logic               f;
        fire_rec_t          r;
        n = 0;
        f = 1'b0;
        case (cmd)
            CMD_TICK:
            begin
                while (n < MAX_FIRES)
                begin
                    best = -1;
                    best_late = '0;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        late = now - slot_tgt[i];
                        if (slot_run[i] && late < window && (best < 0 || late > best_late))
                        begin
                            best = i;
                            best_late = late;
                        end
                    end
                    if (best < 0)
                        break;
                    if (slot_per[best])
                        slot_tgt[best] = slot_tgt[best] + slot_dly[best];
                    else
                        slot_run[best] = 1'b0;
                    push_result(1'b1, best[ID_W-1:0], now);
                    n++;
                end
                if (n == 0)
                    push_result(1'b0, '0, now);
            end
            CMD_ATTACH:
            begin
                if (!slot_run[id])
                begin
                    slot_dly[id] = dl;
                    slot_per[id] = per;
                    slot_tgt[id] = dl + now;
                    slot_run[id] = 1'b1;
                end
            end
            CMD_DETACH:
                slot_run[id] = 1'b0;
            CMD_CHANGE:
            begin
                if (dl != 0 && !slot_run[id])
                    slot_dly[id] = dl;
                else if (dl != 0)
                begin
                    old = slot_dly[id];
                    rem = slot_tgt[id] - now;
                    // Overdue timers count as having waited longer than any delay.
                    if (rem > old || (old - rem) > dl)
                    begin
                        f = 1'b1;
                        slot_tgt[id] = now + dl;
                    end
                    else
                        slot_tgt[id] = slot_tgt[id] + dl - old;
                    slot_dly[id] = dl;
                end
            end
            CMD_SYNC:
            begin
                if (!slot_run[id])
                begin
                    slot_dly[id] = dl;
                    slot_per[id] = per;
                    start = slot_tgt[rid] - slot_dly[rid];
                    diff = now - start;
                    slot_tgt[id] = (dl == 0) ? now : now + (dl - diff % dl);
                    slot_run[id] = 1'b1;
                end
            end
            CMD_FIRE:
            begin
                f = 1'b1;
                slot_run[id] = slot_per[id];
                if (slot_per[id])
                    slot_tgt[id] = slot_dly[id] + now;
            end
            default: ;
        endcase
        if (cmd != CMD_TICK)
            push_result(f, id, now);
        r = due_results[$];
        due_results.pop_back();
        r.last = 1'b1;
        due_results.push_back(r);
    endfunction

    assign pending_count = due_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        fire_rec_t e;
        fire_rec_t a;
        if (!rst_n)
        begin
            window <= DEFAULT_LATE_WINDOW;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_tgt[i] = '0;
                slot_dly[i] = '0;
                slot_per[i] = 1'b0;
                slot_run[i] = 1'b0;
            end
            due_results.delete();
            fail_count <= 0;
            result_count <= 0;
            fire_count <= 0;
        end
        else
        begin
            // The result is checked before the command of the same edge is predicted.
            if (res.valid && res.ready)
            begin
                a = '{res.fired, res.fired_id, res.compare_value, res.last};
                result_count <= result_count + 1;
                if (res.fired)
                    fire_count <= fire_count + 1;
                if (due_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: fired %0d id %0d compare %h last %0d",
                                 a.fired, a.fired_id, a.compare_value, a.last);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = due_results.pop_front();
                    if (e != a)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected fired %0d id %0d compare %h last %0d, got fired %0d id %0d compare %h last %0d",
                                     e.fired, e.fired_id, e.compare_value, e.last,
                                     a.fired, a.fired_id, a.compare_value, a.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (req.valid && req.ready)
                predict_command(req.cmd, req.timer_id, req.reference_id, req.delay,
                                req.periodic, req.now_count);
            if (late_window_we)
                window <= late_window_wdata;
        end
    end
endmodule

[test/multiplexed_timer_array_unit_tb.sv]
// Testbench top of the multiplexed timer array unit: drives commands and the late
// window register, stalls the result channel, and gives the verdict of the checker.
// Depends on mta_pkg, mta_req_if, mta_res_if, multiplexed_timer_array_unit and its checker.
module multiplexed_timer_array_unit_tb;
    import mta_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               late_window_we;
    logic [FIELD_W-1:0] late_window_wdata;
    int                 fail_count;
    int                 pending_count;
    int                 result_count;
    int                 fire_count;
    int                 idle_pct;
    int                 stall_pct;
    int                 sent;
    logic [FIELD_W-1:0] clock_now;

    mta_req_if req();
    mta_res_if res();

    multiplexed_timer_array_unit dut (
        .clk(clk), .rst_n(rst_n),
        .late_window_we(late_window_we), .late_window_wdata(late_window_wdata),
        .req(req), .res(res)
    );

    multiplexed_timer_array_unit_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .late_window_we(late_window_we), .late_window_wdata(late_window_wdata),
        .req(req), .res(res),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count), .fire_count(fire_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    always @(negedge clk)
        res.ready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

    // Holds valid across back-to-back transfers; it drops only for inserted idle cycles.
    // Ready is looked at on the falling edge, where it is stable until the next rising one.
    task automatic send(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id, logic [ID_W-1:0] rid,
                        logic [FIELD_W-1:0] dl, logic per, logic [FIELD_W-1:0] now);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.cmd = cmd;
        req.timer_id = id;
        req.reference_id = rid;
        req.delay = dl;
        req.periodic = per;
        req.now_count = now;
        req.valid = 1'b1;
        while (!req.ready)
            @(negedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic settle_and_write(logic [FIELD_W-1:0] value);
        req.valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        // The last result has been taken, so the unit is idle before the window write.
        repeat (60) @(negedge clk);
        late_window_we = 1'b1;
        late_window_wdata = value;
        @(negedge clk);
        late_window_we = 1'b0;
    endtask

    task automatic random_item();
        int                 pick;
        logic [FIELD_W-1:0] dl;
        pick = $urandom_range(99);
        clock_now = ($urandom_range(19) == 0) ? 16'($urandom)
                                              : clock_now + 16'($urandom_range(300));
        dl = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
        if (pick < 40)
            send(CMD_TICK, 4'($urandom), 4'($urandom), 16'($urandom), 1'($urandom),
                 clock_now);
        else if (pick < 65)
            send(CMD_ATTACH, 4'($urandom), 4'($urandom), dl, 1'($urandom), clock_now);
        else if (pick < 73)
            send(CMD_DETACH, 4'($urandom), 4'($urandom), dl, 1'($urandom), clock_now);
        else if (pick < 83)
            send(CMD_CHANGE, 4'($urandom), 4'($urandom), dl, 1'($urandom), clock_now);
        else if (pick < 91)
            send(CMD_SYNC, 4'($urandom), 4'($urandom), dl, 1'($urandom), clock_now);
        else if (pick < 97)
            send(CMD_FIRE, 4'($urandom), 4'($urandom), dl, 1'($urandom), clock_now);
        else
            send(3'($urandom_range(7, 6)), 4'($urandom), 4'($urandom), 16'($urandom),
                 1'($urandom), clock_now);
    endtask

    initial
    begin
        rst_n = 1'b0;
        late_window_we = 1'b0;
        late_window_wdata = '0;
        req.valid = 1'b0;
        req.cmd = CMD_TICK;
        req.timer_id = '0;
        req.reference_id = '0;
        req.delay = '0;
        req.periodic = 1'b0;
        req.now_count = '0;
        res.ready = 1'b1;
        idle_pct = 0;
        stall_pct = 0;
        sent = 0;
        clock_now = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        settle_and_write(16'd1000);

        // Empty ticks, ties, re-arming and the change-delay cases.
        send(CMD_TICK,   4'd0,  4'd0,  16'd0,     1'b0, 16'd0);
        send(CMD_ATTACH, 4'd0,  4'd0,  16'd10,    1'b0, 16'd0);
        send(CMD_ATTACH, 4'd15, 4'd0,  16'hFFFF,  1'b1, 16'hFFFF);
        send(CMD_ATTACH, 4'd0,  4'd0,  16'd5,     1'b1, 16'd3);
        send(CMD_TICK,   4'd0,  4'd0,  16'd0,     1'b0, 16'd10);
        send(CMD_ATTACH, 4'd1,  4'd0,  16'd20,    1'b1, 16'd10);
        send(CMD_ATTACH, 4'd2,  4'd0,  16'd20,    1'b0, 16'd10);
        send(CMD_TICK,   4'd0,  4'd0,  16'd0,     1'b0, 16'd30);
        send(CMD_CHANGE, 4'd1,  4'd0,  16'd0,     1'b0, 16'd30);
        send(CMD_CHANGE, 4'd3,  4'd0,  16'd7,     1'b0, 16'd30);
        send(CMD_CHANGE, 4'd1,  4'd0,  16'd5,     1'b0, 16'd30);
        send(CMD_CHANGE, 4'd1,  4'd0,  16'd2,     1'b0, 16'd40);
        send(CMD_DETACH, 4'd5,  4'd0,  16'd0,     1'b0, 16'd40);
        send(CMD_DETACH, 4'd1,  4'd0,  16'd0,     1'b0, 16'd41);
        send(CMD_SYNC,   4'd4,  4'd15, 16'd300,   1'b1, 16'd1000);
        send(CMD_SYNC,   4'd5,  4'd6,  16'd0,     1'b0, 16'd77);
        send(CMD_SYNC,   4'd4,  4'd0,  16'd9,     1'b0, 16'd78);
        send(CMD_FIRE,   4'd4,  4'd0,  16'd0,     1'b0, 16'd1100);
        send(CMD_FIRE,   4'd6,  4'd0,  16'd0,     1'b0, 16'd1101);
        send(CMD_FIRE,   4'd15, 4'd0,  16'd0,     1'b0, 16'd1102);
        send(3'd6,       4'd7,  4'd7,  16'hAAAA,  1'b1, 16'd1103);
        send(3'd7,       4'd8,  4'd8,  16'h5555,  1'b0, 16'd1104);
        // A periodic timer with no delay stays due, so the tick stops at its cap.
        send(CMD_ATTACH, 4'd7,  4'd0,  16'd0,     1'b1, 16'd500);
        send(CMD_TICK,   4'd0,  4'd0,  16'd0,     1'b0, 16'd500);
        send(CMD_DETACH, 4'd7,  4'd0,  16'd0,     1'b0, 16'd501);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            for (int k = 0; k < 37; k++)
                random_item();
            case (ph)
                0: settle_and_write(16'd1);
                1: settle_and_write(16'hFFFF);
                2: settle_and_write(16'($urandom_range(65535, 1)));
                default: settle_and_write(16'd1000);
            endcase
        end

        repeat (100) @(negedge clk);
        $display("Sent %0d commands over four handshake phases and window settings from 1 to 65535;",
                 sent);
        $display("checked %0d results, %0d of them firings.", result_count, fire_count);
        if (fail_count == 0 && pending_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/mta_pkg.sv
rtl/core/mta_req_if.sv
rtl/core/mta_res_if.sv
rtl/core/mta_ram.sv
rtl/core/mta_div.sv
rtl/core/multiplexed_timer_array_unit.sv
test/multiplexed_timer_array_unit_checker.sv
test/multiplexed_timer_array_unit_tb.sv
